// File: hdl/tclr_pkg.sv
// Shared types, constants and helpers for the text console line ring.
`default_nettype none
package tclr_pkg;

	localparam int MAX_LINES = 64;
	localparam int MAX_COLS  = 128;
	localparam int LINE_W    = 6;
	localparam int COL_W     = 8;
	localparam int ADDR_W    = LINE_W + COL_W;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [7:0] W_MAX = 8'(MAX_COLS);
	localparam logic [6:0] L_MAX = 7'(MAX_LINES);

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_SCROLL = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_LINE_WIDTH   = 3'd0,
		REG_LINES_IN_USE = 3'd1,
		REG_VIS_HEIGHT   = 3'd2,
		REG_STOP_FULL    = 3'd3,
		REG_DBL_BYTE     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE, S_TAB, S_FIN, S_WRAP, S_LEAD, S_MOD, S_RD, S_OUT
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       char_byte;
		logic signed [7:0] scroll_amount;
		logic [5:0]       read_row;
		logic [6:0]       read_column;
	} item_t;

	typedef struct packed {
		logic [7:0] line_width;
		logic [6:0] lines_in_use;
		logic [6:0] visible_height;
		logic       stop_when_full;
		logic       double_byte_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       row_valid;
		logic       accepted;
		logic [5:0] view_top;
		logic [5:0] oldest_line;
		logic [5:0] current_line;
		logic [7:0] current_column;
	} res_t;

	function automatic logic [5:0] ring_next(input logic [5:0] i, input logic [6:0] l);
		logic [6:0] s;
		s = {1'b0, i} + 7'd1;
		return (s >= l) ? 6'd0 : s[5:0];
	endfunction

	function automatic logic signed [9:0] ring_diff(input logic [5:0] a, input logic [5:0] b,
			input logic [6:0] l);
		logic signed [9:0] d;
		d = $signed({4'b0, b}) - $signed({4'b0, a});
		if (d < 0)
			d = d + $signed({3'b0, l});
		return d;
	endfunction

	function automatic logic is_lead(input logic [7:0] b);
		return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
	endfunction

endpackage
`default_nettype wire

// File: hdl/tclr_front.sv
// Front end: takes transactions in and holds them in a two-entry queue for the sequencer.
`default_nettype none
module tclr_front
	import tclr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  char_byte,
	input  wire logic signed [7:0] scroll_amount,
	input  wire logic [5:0]  read_row,
	input  wire logic [6:0]  read_column,
	output item_t            head,
	output logic             head_valid,
	input  wire logic        take
);

	item_t      entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;
	item_t      incoming;

	always_comb begin
		incoming.op            = op_t'(operation);
		incoming.char_byte     = char_byte;
		incoming.scroll_amount = scroll_amount;
		incoming.read_row      = read_row;
		incoming.read_column   = read_column;
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != 2'd0);
	assign pop        = take && head_valid;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= incoming;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count overflow");
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> head_valid) else $error("take from empty queue");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("push lost");
`endif

endmodule
`default_nettype wire

// File: hdl/tclr_back.sv
// Back end: sequencer that carries out console operations on the line store.
`default_nettype none
module tclr_back
	import tclr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire logic  item_valid,
	output logic       item_take,
	output res_t       res,
	output logic       res_valid,
	input  wire logic  res_stall
);

	logic [7:0] mem [2**ADDR_W];
	logic [7:0] rdata_q;

	state_t state_q, state_d;

	logic [MAX_LINES-1:0] line_valid_q;
	logic [5:0] top_q, oldest_q, wline_q;
	logic [7:0] wcol_q, pos_q;
	logic       trail_q, lead_cont_q, acc_q, neg_q, rvalid_q;
	logic [7:0] byte_q, col_q, mag_q;
	op_t        op_q;
	logic [6:0] rem_q;
	logic [2:0] cnt_q;
	res_t       res_q;
	logic       res_valid_q;

	logic [7:0] w_eff;
	logic [6:0] l_eff, h_eff;
	logic       full, is_nl, is_tab, is_ld, out_load;
	logic [7:0] wcol_inc, tab_next;
	logic [5:0] nl, t1, t2, o2, mod_res;
	logic [7:0] r2, r_sub;
	logic [6:0] rem_next;
	logic signed [9:0] amt, dlim, t_sum, h_s;
	logic [7:0] mag_in;

	logic       mem_we;
	logic [5:0] mem_line;
	logic [7:0] mem_col, mem_wdata;

	always_comb begin
		w_eff = (cfg.line_width == 8'd0) ? 8'd1 :
			((cfg.line_width > W_MAX) ? W_MAX : cfg.line_width);
		l_eff = (cfg.lines_in_use == 7'd0) ? 7'd1 :
			((cfg.lines_in_use > L_MAX) ? L_MAX : cfg.lines_in_use);
		h_eff = (cfg.visible_height < l_eff) ? cfg.visible_height : l_eff;
		h_s   = $signed({3'b0, h_eff});
	end

	assign full     = cfg.stop_when_full && (oldest_q == ring_next(wline_q, l_eff));
	assign wcol_inc = wcol_q + 8'd1;
	assign tab_next = wcol_q + 8'd1;
	assign is_nl    = (item.char_byte == CH_NL);
	assign is_tab   = (item.char_byte == CH_TAB);
	assign is_ld    = cfg.double_byte_enable && is_lead(item.char_byte);
	assign out_load = !res_valid_q || !res_stall;

	// wrap bookkeeping
	always_comb begin
		nl = ring_next(wline_q, l_eff);
		t1 = (ring_diff(top_q, nl, l_eff) == h_s) ? ring_next(top_q, l_eff) : top_q;
		o2 = (nl == oldest_q) ? ring_next(oldest_q, l_eff) : oldest_q;
		t2 = (nl == t1) ? ring_next(t1, l_eff) : t1;
	end

	// scroll clamp
	always_comb begin
		amt  = $signed({{2{item.scroll_amount[7]}}, item.scroll_amount});
		dlim = '0;
		if (amt < 0) begin
			dlim = ring_diff(oldest_q, top_q, l_eff);
			if (amt < -dlim)
				amt = -dlim;
		end else if (amt > 0) begin
			if (ring_diff(oldest_q, wline_q, l_eff) + 10'sd1 <= h_s) begin
				amt = '0;
			end else begin
				dlim = ring_diff(top_q, wline_q, l_eff) - h_s + 10'sd1;
				if (amt > dlim)
					amt = dlim;
			end
		end
		t_sum  = $signed({4'b0, top_q}) + amt;
		mag_in = (t_sum < 0) ? 8'(-t_sum) : 8'(t_sum);
	end

	// one restoring remainder step per cycle
	always_comb begin
		r2       = {rem_q, mag_q[7]};
		r_sub    = r2 - {1'b0, l_eff};
		rem_next = (r2 >= {1'b0, l_eff}) ? r_sub[6:0] : r2[6:0];
		mod_res  = (neg_q && (rem_q != 7'd0)) ? 6'(l_eff - rem_q) : rem_q[5:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					unique case (item.op) inside
						OP_PUT: begin
							if (trail_q)
								state_d = S_FIN;
							else if (full)
								state_d = S_OUT;
							else if (is_tab && (wcol_q < w_eff))
								state_d = S_TAB;
							else
								state_d = S_FIN;
						end
						OP_CLEAR: state_d = S_OUT;
						OP_SCROLL, OP_READ: state_d = S_MOD;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_TAB: begin
				if ((tab_next[2:0] == 3'd0) || (tab_next >= w_eff))
					state_d = S_FIN;
			end
			S_FIN: state_d = (wcol_q < w_eff) ? S_OUT : S_WRAP;
			S_WRAP: state_d = lead_cont_q ? S_LEAD : S_OUT;
			S_LEAD: state_d = full ? S_OUT : S_FIN;
			S_MOD: begin
				if (cnt_q == 3'd7)
					state_d = S_RD;
			end
			S_RD: state_d = S_OUT;
			S_OUT: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_take = 1'b0;
		mem_we    = 1'b0;
		mem_line  = wline_q;
		mem_col   = wcol_q;
		mem_wdata = CH_NUL;
		unique case (state_q)
			S_IDLE: begin
				item_take = item_valid;
				if (item_valid) begin
					unique case (item.op)
						OP_PUT: begin
							if (trail_q) begin
								mem_we    = 1'b1;
								mem_wdata = item.char_byte;
							end else if (!full && !is_nl && !is_tab) begin
								mem_we    = 1'b1;
								mem_wdata = (is_ld && (wcol_inc >= w_eff)) ? CH_NUL
									: item.char_byte;
							end
						end
						OP_CLEAR: begin
							mem_we   = 1'b1;
							mem_line = '0;
							mem_col  = '0;
						end
						default: mem_we = 1'b0;
					endcase
				end
			end
			S_TAB: begin
				mem_we    = 1'b1;
				mem_col   = pos_q;
				mem_wdata = CH_SPACE;
			end
			S_FIN: begin
				mem_we  = 1'b1;
				mem_col = pos_q;
			end
			S_WRAP: begin
				mem_we   = 1'b1;
				mem_line = nl;
				mem_col  = '0;
			end
			S_LEAD: begin
				mem_we    = !full;
				mem_col   = '0;
				mem_wdata = byte_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we && (mem_col <= W_MAX))
			mem[{mem_line, mem_col}] <= mem_wdata;
		rdata_q <= mem[{mod_res, col_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			line_valid_q <= {{(MAX_LINES-1){1'b0}}, 1'b1};
			top_q        <= '0;
			oldest_q     <= '0;
			wline_q      <= '0;
			wcol_q       <= '0;
			trail_q      <= 1'b0;
			lead_cont_q  <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && item.op == OP_PUT) begin
						if (trail_q) begin
							trail_q <= 1'b0;
							wcol_q  <= wcol_inc;
						end else if (!full) begin
							if (is_nl)
								wcol_q <= w_eff;
							else if (is_ld) begin
								wcol_q <= wcol_inc;
								if (wcol_inc >= w_eff)
									lead_cont_q <= 1'b1;
								else
									trail_q <= 1'b1;
							end else if (!is_tab)
								wcol_q <= wcol_inc;
						end
					end else if (item_valid && item.op == OP_CLEAR) begin
						top_q        <= '0;
						oldest_q     <= '0;
						wline_q      <= '0;
						wcol_q       <= '0;
						trail_q      <= 1'b0;
						line_valid_q <= {{(MAX_LINES-1){1'b0}}, 1'b1};
					end
				end
				S_TAB: wcol_q <= tab_next;
				S_WRAP: begin
					wline_q          <= nl;
					wcol_q           <= '0;
					line_valid_q[nl] <= 1'b1;
					oldest_q         <= o2;
					top_q            <= t2;
				end
				S_LEAD: begin
					lead_cont_q <= 1'b0;
					if (!full) begin
						trail_q <= (w_eff > 8'd1);
						wcol_q  <= 8'd1;
					end
				end
				S_RD: begin
					if (op_q == OP_SCROLL)
						top_q <= mod_res;
				end
				default: wcol_q <= wcol_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					byte_q <= item.char_byte;
					op_q   <= item.op;
					col_q  <= {1'b0, item.read_column};
					acc_q  <= !(item.op == OP_PUT && !trail_q && full);
					rem_q  <= '0;
					cnt_q  <= '0;
					if (item.op == OP_READ) begin
						mag_q <= {2'b0, top_q} + {2'b0, item.read_row};
						neg_q <= 1'b0;
					end else begin
						mag_q <= mag_in;
						neg_q <= (t_sum < 0);
					end
					if (trail_q || is_ld || (!is_nl && !is_tab))
						pos_q <= wcol_inc;
					else
						pos_q <= wcol_q;
				end
			end
			S_TAB: pos_q <= pos_q + 8'd1;
			S_LEAD: begin
				pos_q <= 8'd1;
				if (full)
					acc_q <= 1'b0;
			end
			S_MOD: begin
				rem_q <= rem_next;
				mag_q <= {mag_q[6:0], 1'b0};
				cnt_q <= cnt_q + 3'd1;
			end
			S_RD: rvalid_q <= line_valid_q[mod_res];
			S_OUT: begin
				if (out_load) begin
					res_q.read_byte      <= (op_q == OP_READ && col_q <= W_MAX) ? rdata_q
						: CH_NUL;
					res_q.row_valid      <= (op_q == OP_READ) && rvalid_q;
					res_q.accepted       <= acc_q;
					res_q.view_top       <= top_q;
					res_q.oldest_line    <= oldest_q;
					res_q.current_line   <= wline_q;
					res_q.current_column <= wcol_q;
				end
			end
			default: pos_q <= pos_q;
		endcase
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcol_q <= W_MAX + 8'd1) else $error("write column beyond store");
	a_line_valid: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid_q[wline_q]) else $error("write line not marked valid");
	a_lead_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEAD) |-> (wcol_q == 8'd0)) else $error("lead placed off line start");
`endif

endmodule
`default_nettype wire

// File: hdl/text_console_line_ring_core.sv
// Top level of the text console line ring: configuration registers and block wiring.
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transaction:
//   put byte, scroll, clear or read cell. A transaction is taken when in_valid
//   is high and in_stall low; a two-entry queue lets the sender run ahead.
//   Output channel (out_valid / out_stall) returns one result per operation,
//   in order, with the console indices after that operation.
//   Configuration writes go through cfg_valid / cfg_ready (always ready),
//   register index on cfg_index, value on cfg_data; write only while idle.
// Timing: the sequencer writes one line store cell per cycle.
//   put: writes the byte and a closing NUL cell, plus a wrap step on a line wrap,
//   plus tab padding, plus a lead byte pushed to the next line.
//   scroll and read: run through the 8-step remainder unit.
//   clear: resets the indices and writes a NUL to cell 0 of line 0.
// Reset: indices cleared, line 0 marked valid, registers to their defaults;
//   the line store is not cleared. A stalled result holds in the output
//   register while the next operation runs up to its own result.
`default_nettype none
module text_console_line_ring_core
	import tclr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  char_byte,
	input  wire logic signed [7:0] scroll_amount,
	input  wire logic [5:0]  read_row,
	input  wire logic [6:0]  read_column,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_byte,
	output logic             row_valid,
	output logic             accepted,
	output logic [5:0]       view_top,
	output logic [5:0]       oldest_line,
	output logic [5:0]       current_line,
	output logic [7:0]       current_column,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	cfg_t  cfg_q;
	item_t head;
	logic  head_valid, take;
	res_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width         <= 8'd80;
			cfg_q.lines_in_use       <= 7'd64;
			cfg_q.visible_height     <= 7'd20;
			cfg_q.stop_when_full     <= 1'b0;
			cfg_q.double_byte_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LINE_WIDTH:   cfg_q.line_width         <= cfg_data;
				REG_LINES_IN_USE: cfg_q.lines_in_use       <= cfg_data[6:0];
				REG_VIS_HEIGHT:   cfg_q.visible_height     <= cfg_data[6:0];
				REG_STOP_FULL:    cfg_q.stop_when_full     <= cfg_data[0];
				REG_DBL_BYTE:     cfg_q.double_byte_enable <= cfg_data[0];
				default:          cfg_q                    <= cfg_q;
			endcase
		end
	end

	tclr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.char_byte     (char_byte),
		.scroll_amount (scroll_amount),
		.read_row      (read_row),
		.read_column   (read_column),
		.head          (head),
		.head_valid    (head_valid),
		.take          (take)
	);

	tclr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (head),
		.item_valid (head_valid),
		.item_take  (take),
		.res        (res),
		.res_valid  (out_valid),
		.res_stall  (out_stall)
	);

	assign read_byte      = res.read_byte;
	assign row_valid      = res.row_valid;
	assign accepted       = res.accepted;
	assign view_top       = res.view_top;
	assign oldest_line    = res.oldest_line;
	assign current_line   = res.current_line;
	assign current_column = res.current_column;

endmodule
`default_nettype wire
